// ----- rtl/owrb_pkg.sv -----
// shared constants for the overwrite ring buffer with frame scan
// store depth, field widths, command and status codes, register map
// no dependencies
package owrb_pkg;

    localparam int DEPTH    = 256;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    // apb register map
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_BIT = 2;

    localparam logic REG_START_KEYWORD = 1'b0;
    localparam logic REG_END_KEYWORD   = 1'b1;

    localparam logic [BYTE_W-1:0] START_KEYWORD_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_KEYWORD_RST   = 8'h03;

    // lowest byte that counts as frame text
    localparam logic [BYTE_W-1:0] TEXT_MIN = 8'h20;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 2'd3;

endpackage

// ----- rtl/owrb_if.sv -----
// valid/ready channel interfaces for commands and results
// depends on owrb_pkg
interface owrb_item_if
    import owrb_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface owrb_result_if
    import owrb_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_byte;
    logic [BYTE_W-1:0]   frame_length;
    logic [BYTE_W-1:0]   frame_offset;

    modport source (output valid, output status, output read_byte, output frame_length,
                    output frame_offset, input ready);
    modport sink   (input valid, input status, input read_byte, input frame_length,
                    input frame_offset, output ready);
endinterface

// ----- rtl/overwrite_ring_buffer_frame_scan.sv -----
// byte ring buffer with overwrite and a frame scanner over the stored bytes
// write, empty read/query, unknown command: result valid in the cycle after the transfer
// read: one synchronous read of the byte store, then the registered result; query: scans n
// bytes (up to DEPTH-1), one store read per cycle, then the result; one command at a time
// reset: pointers to zero, keywords to 0x02/0x03; byte store contents are not cleared
// depends on owrb_pkg and owrb_if
module overwrite_ring_buffer_frame_scan
    import owrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    owrb_item_if.sink          item,
    owrb_result_if.source      result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SCAN} state_t;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] sat8(input logic [PTR_W-1:0] v);
        logic [PTR_W+7:0] w;
        w = {8'b0, v};
        return (w > (PTR_W + 8)'(255)) ? 8'hFF : w[7:0];
    endfunction

    // configuration registers
    logic [BYTE_W-1:0] start_kw_reg;
    logic [BYTE_W-1:0] end_kw_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = {{(PDATA_W - BYTE_W){1'b0}},
                        (paddr[REG_IDX_BIT] == REG_END_KEYWORD) ? end_kw_reg : start_kw_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_kw_reg <= START_KEYWORD_RST;
            end_kw_reg   <= END_KEYWORD_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[REG_IDX_BIT] == REG_END_KEYWORD)
                end_kw_reg <= pwdata[BYTE_W-1:0];
            else
                start_kw_reg <= pwdata[BYTE_W-1:0];
        end
    end

    // byte store
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] mem_q;
    logic              mem_we;
    logic [PTR_W-1:0]  rd_addr;

    // control and scan state
    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    scan_ptr_reg, scan_ptr_next;
    logic [PTR_W-1:0]    off_reg, off_next;
    logic [PTR_W-1:0]    len_reg, len_next;
    logic [PTR_W-1:0]    found_reg, found_next;
    logic                chk_reg, chk_next;
    logic                open_reg, open_next;
    logic                text_done_reg, text_done_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0]   rbyte_reg, rbyte_next;
    logic [BYTE_W-1:0]   flen_reg, flen_next;
    logic [BYTE_W-1:0]   foff_reg, foff_next;

    logic item_xfer;
    logic empty;

    assign item.ready = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign item_xfer  = item.valid && item.ready;
    assign empty      = (rp_reg == wp_reg);

    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.read_byte    = rbyte_reg;
    assign result.frame_length = flen_reg;
    assign result.frame_offset = foff_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= item.data_byte;
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        logic [PTR_W-1:0] off_inc;
        logic             done_now;

        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        scan_ptr_next  = scan_ptr_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        found_next     = found_reg;
        chk_next       = chk_reg;
        open_next      = open_reg;
        text_done_next = text_done_reg;
        out_valid_next = out_valid_reg && !result.ready;
        status_next    = status_reg;
        rbyte_next     = rbyte_reg;
        flen_next      = flen_reg;
        foff_next      = foff_reg;
        mem_we         = 1'b0;
        rd_addr        = rp_reg;
        off_inc        = off_reg + 1'b1;
        done_now       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    status_next = STATUS_OK;
                    rbyte_next  = '0;
                    flen_next   = '0;
                    foff_next   = '0;
                    case (item.command)
                        CMD_WRITE:
                        begin
                            mem_we         = 1'b1;
                            wp_next        = adv(wp_reg);
                            out_valid_next = 1'b1;
                            // pointers meet: drop the oldest byte
                            if (adv(wp_reg) == rp_reg)
                            begin
                                rp_next     = adv(rp_reg);
                                status_next = STATUS_FULL;
                            end
                        end
                        CMD_READ:
                        begin
                            if (empty)
                            begin
                                status_next    = STATUS_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = rp_reg;
                                rp_next    = adv(rp_reg);
                                state_next = ST_READ;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (empty)
                            begin
                                status_next    = STATUS_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr        = rp_reg;
                                scan_ptr_next  = adv(rp_reg);
                                off_next       = '0;
                                len_next       = '0;
                                found_next     = '0;
                                chk_next       = 1'b0;
                                open_next      = 1'b0;
                                text_done_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rbyte_next     = mem_q;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SCAN:
            begin
                // mem_q holds the byte at offset off_inc; the next read goes out meanwhile
                off_next = off_inc;
                if (mem_q == start_kw_reg)
                begin
                    found_next     = off_inc;
                    len_next       = PTR_W'(1);
                    chk_next       = 1'b0;
                    open_next      = 1'b1;
                    text_done_next = 1'b0;
                end
                else if (mem_q >= TEXT_MIN && open_reg && !text_done_reg)
                begin
                    len_next = len_reg + 1'b1;
                end
                else if (mem_q == end_kw_reg && open_reg)
                begin
                    len_next       = len_reg + 1'b1;
                    text_done_next = 1'b1;
                end
                else if (open_reg && text_done_reg)
                begin
                    len_next = len_reg + 1'b1;
                    chk_next = 1'b1;
                    done_now = chk_reg;
                end

                rd_addr = scan_ptr_reg;
                if (done_now || scan_ptr_reg == wp_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (done_now)
                    begin
                        status_next = STATUS_OK;
                        flen_next   = sat8(len_next);
                        foff_next   = sat8(found_next);
                    end
                    else
                    begin
                        status_next = STATUS_INCOMPLETE;
                    end
                end
                else
                begin
                    scan_ptr_next = adv(scan_ptr_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg  <= scan_ptr_next;
        off_reg       <= off_next;
        len_reg       <= len_next;
        found_reg     <= found_next;
        chk_reg       <= chk_next;
        open_reg      <= open_next;
        text_done_reg <= text_done_next;
        status_reg    <= status_next;
        rbyte_reg     <= rbyte_next;
        flen_reg      <= flen_next;
        foff_reg      <= foff_next;
    end

    // the frame never reaches back past its own start keyword
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (len_reg <= off_reg) && (found_reg <= off_reg))
        else $error("frame scan counters out of order");

    // a write transfer produces its result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && item.command == CMD_WRITE |=> result.valid)
        else $error("write result missing");

    // a complete frame holds at least start, end and two check bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == STATUS_OK && result.frame_length != '0
        |-> result.frame_length >= 8'd4 && result.frame_offset != '0)
        else $error("short frame reported");

    // pointers stay inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg <= PTR_W'(DEPTH - 1)) && (wp_reg <= PTR_W'(DEPTH - 1)))
        else $error("pointer out of range");

    // a read of a nonempty store enters the read state with no earlier result still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && item.command == CMD_READ && !empty
        |=> state_reg == ST_READ && !result.valid)
        else $error("read did not start cleanly");

endmodule
